@@ rtl/lbha_pkg.sv @@
// Shared types and constants for the letter bucket histogram with argmax.
// No dependencies; imported by every module of the block.
package lbha_pkg;

  localparam int unsigned LetterCount = 26;
  localparam int unsigned LetterW     = 5;
  localparam int unsigned IdBits      = 20;
  localparam int unsigned CountBits   = 10;

  localparam logic [7:0] CharA = 8'h41;
  localparam logic [7:0] CharZ = 8'h5A;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HDR,
    ST_IDS
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [IdBits-1:0]   record_id;
    logic [7:0]          character;
  } item_t;

  typedef struct packed {
    logic                 is_header;
    logic [6:0]           letter;
    logic [CountBits-1:0] count;
    logic                 overflowed;
    logic [IdBits-1:0]    record_id_res;
    logic                 last;
  } res_t;

endpackage

@@ rtl/lbha_id_mem.sv @@
// Id list storage: one write port, one read port with registered data.
// Depends on lbha_pkg for the id width.
module lbha_id_mem import lbha_pkg::*; #(
  parameter int unsigned Depth = 832,
  parameter int unsigned AddrW = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [IdBits-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [IdBits-1:0] rdata_o
);

  logic [IdBits-1:0] mem_q [Depth];
  logic [IdBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/letter_bucket_histogram_argmax_unit.sv @@
// Top level of the letter bucket histogram with argmax report.
// Depends on lbha_pkg and lbha_id_mem.
//
// Usage:
//   Command words arrive on item_i and are taken at a clock edge where start_i
//   is high and busy_o is low. Add and clear words complete in the cycle they
//   are taken, so busy_o stays low and a new word may follow every cycle.
//   A report word raises busy_o: a single comparator walks the 26 letter
//   counters, one per cycle, then the header word is built and the winner's
//   ids are read from the list RAM, one per cycle.
//   Result words appear on res_o for exactly one cycle with res_valid_o high;
//   the receiver cannot hold them off. The header is loaded into the output
//   register from the header state that follows the scan; the n ids follow
//   back to back, the final word flagged by last (n = stored ids of the
//   winner, at most LIST_DEPTH). busy_o stays high from the report being
//   taken until the final word is loaded into the output register.
//   Reset (rst_ni low, asynchronous) zeroes all counts, fill levels and
//   overflow flags; the list RAM is not cleared and needs no clearing pass,
//   since only entries below a letter's fill level are ever read.
module letter_bucket_histogram_argmax_unit import lbha_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  item_t item_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  // List index and fill widths follow from the list depth
  localparam int unsigned IdxW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AddrW = LetterW + IdxW;
  localparam int unsigned MemDepth = LetterCount << IdxW;

  state_e state_q, state_d;

  logic [CountBits-1:0] counts_q  [LetterCount];
  logic [FillW-1:0]     fill_q    [LetterCount];
  logic [LetterCount-1:0] dropped_q;

  logic [LetterW-1:0]   scan_idx_q, scan_idx_d;
  logic [LetterW-1:0]   win_q, win_d;
  logic [CountBits-1:0] best_q, best_d;
  logic [FillW-1:0]     rd_idx_q, rd_idx_d;

  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  // Accept decode
  logic               accept;
  logic               is_letter;
  logic               add_go;
  logic               clear_go;
  logic               report_go;
  logic [LetterW-1:0] add_idx;

  assign accept    = start_i && !busy_o;
  assign is_letter = (item_i.character >= CharA) && (item_i.character <= CharZ);
  assign add_idx   = LetterW'(item_i.character - CharA);
  assign add_go    = accept && (item_i.action == ACT_ADD) && is_letter;
  assign clear_go  = accept && (item_i.action == ACT_CLEAR);
  assign report_go = accept && (item_i.action == ACT_REPORT);

  // Single read port on the per-letter state: the add letter when idle,
  // the scan pointer while scanning, the winner while reporting.
  logic [LetterW-1:0]   sel_idx;
  logic [CountBits-1:0] cnt_sel;
  logic [FillW-1:0]     fill_sel;
  logic                 drop_sel;

  always_comb begin
    unique case (state_q)
      ST_IDLE: sel_idx = add_idx;
      ST_SCAN: sel_idx = scan_idx_q;
      default: sel_idx = win_q;
    endcase
  end

  assign cnt_sel  = counts_q[sel_idx];
  assign fill_sel = fill_q[sel_idx];
  assign drop_sel = dropped_q[sel_idx];

  logic list_full;
  assign list_full = (fill_sel == FillW'(LIST_DEPTH));

  // Counters, fill levels and overflow flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LetterCount; i++) begin
        counts_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      dropped_q <= '0;
    end else if (clear_go) begin
      for (int i = 0; i < LetterCount; i++) begin
        counts_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      dropped_q <= '0;
    end else if (add_go) begin
      if (cnt_sel != '1) begin
        counts_q[add_idx] <= cnt_sel + CountBits'(1);
      end
      if (list_full) begin
        dropped_q[add_idx] <= 1'b1;
      end else begin
        fill_q[add_idx] <= fill_sel + FillW'(1);
      end
    end
  end

  // Id list RAM
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [AddrW-1:0]  mem_raddr;
  logic [IdBits-1:0] mem_rdata;

  assign mem_we    = add_go && !list_full;
  assign mem_waddr = {add_idx, fill_sel[IdxW-1:0]};

  lbha_id_mem #(
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_id_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (item_i.record_id),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      win_q       <= '0;
      best_q      <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      win_q       <= win_d;
      best_q      <= best_d;
      rd_idx_q    <= rd_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  logic [6:0] win_letter;
  assign win_letter = CharA[6:0] + {2'b00, win_q};

  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    win_d       = win_q;
    best_d      = best_q;
    rd_idx_d    = rd_idx_q;
    res_valid_d = 1'b0;
    mem_raddr   = {win_q, rd_idx_q[IdxW-1:0]};

    res_d.is_header     = 1'b0;
    res_d.letter        = win_letter;
    res_d.count         = best_q;
    res_d.overflowed    = drop_sel;
    res_d.record_id_res = mem_rdata;
    res_d.last          = (rd_idx_q == fill_sel);

    unique case (state_q)
      ST_IDLE: begin
        if (report_go) begin
          state_d    = ST_SCAN;
          scan_idx_d = '0;
          win_d      = '0;
          best_d     = '0;
        end
      end
      ST_SCAN: begin
        // strict compare: the lowest letter keeps a tie
        if (cnt_sel > best_q) begin
          best_d = cnt_sel;
          win_d  = scan_idx_q;
        end
        if (scan_idx_q == LetterW'(LetterCount - 1)) begin
          state_d = ST_HDR;
        end else begin
          scan_idx_d = scan_idx_q + LetterW'(1);
        end
      end
      ST_HDR: begin
        res_valid_d         = 1'b1;
        res_d.is_header     = 1'b1;
        res_d.record_id_res = '0;
        res_d.last          = (fill_sel == '0);
        mem_raddr           = {win_q, IdxW'(0)};
        rd_idx_d            = FillW'(1);
        state_d             = (fill_sel == '0) ? ST_IDLE : ST_IDS;
      end
      ST_IDS: begin
        // rdata holds entry rd_idx_q-1; fetch entry rd_idx_q
        res_valid_d = 1'b1;
        rd_idx_d    = rd_idx_q + FillW'(1);
        if (rd_idx_q == fill_sel) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(busy_o))
    else $error("result word without a report in flight");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |=> !res_valid_q)
    else $error("result word after last");

  a_id_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.is_header |-> $past(res_valid_q))
    else $error("id word without a preceding word");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> scan_idx_q < LetterW'(LetterCount))
    else $error("scan pointer beyond last letter");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> fill_sel <= FillW'(LIST_DEPTH))
    else $error("fill level beyond list depth");

endmodule
